@@ hdl/amge_pkg.sv @@
// Shared definitions for the adjacency matrix graph engine.
// Field widths, command and error codes, register indexes and the
// command/status structs between the controller and the datapath.
package amge_pkg;

   // Default size of the vertex set
   localparam int MAX_VERTICES_DEFAULT = 16;

   // Fixed field widths
   localparam int KIND_W      = 3;
   localparam int VERTEX_W    = 4;
   localparam int DEG_W       = 5;
   localparam int TDEG_W      = 6;
   localparam int COUNT_W     = 5;
   localparam int EDGE_W      = 9;
   localparam int ERR_W       = 2;
   localparam int START_W     = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // At most this many results per listing
   localparam int MAX_RESULTS  = 16;
   localparam int RESULT_CNT_W = 4;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_EDGE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_EDGE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD_VERTEX    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE_VERTEX = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUERY         = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LIST          = 3'd6;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   // Register select (word address bit 2)
   localparam logic CSR_DIRECTED_MODE  = 1'b0;
   localparam logic CSR_START_VERTICES = 1'b1;

   localparam logic [START_W-1:0] START_RESET = 5'd16;

   // Datapath micro-operations
   typedef enum logic [4:0] {
      DP_NOP,
      DP_TAKE,
      DP_CHECK,
      DP_CLEAR,
      DP_ADD_VERTEX,
      DP_RD_FIRST,
      DP_RD_SECOND,
      DP_WR_EDGE_A,
      DP_WR_EDGE_B,
      DP_RM_READ,
      DP_RM_WRITE,
      DP_RM_FINISH,
      DP_Q_CAPTURE,
      DP_Q_READ,
      DP_Q_ACC,
      DP_LIST_CAPTURE,
      DP_LIST_SKIP,
      DP_LIST_EMIT,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              err_none;
      logic              directed;
      logic              sweep_last;
      logic              scan_hit;
      logic              list_last;
      logic              row_empty;
      logic              out_free;
   } dp_status_type;

endpackage

@@ hdl/adjacency_matrix_graph_engine.sv @@
// Adjacency matrix graph engine. The graph is held as one row of
// MAX_VERTICES bits per vertex in a single-port-read RAM; a controller
// steps each item through the datapath one row access at a time, so items
// are handled one after another. An error goes straight to the result;
// add/remove edge reads and writes one row (the mirrored row takes a second
// read and write when undirected), remove vertex and query read every live
// row once (query reads its own row first), and listing tests one column
// per cycle while the result channel does not stall. A new item is taken
// while the last result still waits in the output register. Clear
// invalidates rows rather than sweeping them. Edge total counts set bits,
// halved when undirected; the directed mode register only changes how
// counts and new edges are treated, existing bits stay.
module adjacency_matrix_graph_engine #(
   parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [amge_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [amge_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [amge_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   // item channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [amge_pkg::KIND_W-1:0]     req_kind,
   input  logic [amge_pkg::VERTEX_W-1:0]   req_first_vertex,
   input  logic [amge_pkg::VERTEX_W-1:0]   req_second_vertex,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_edge_present,
   output logic [amge_pkg::DEG_W-1:0]      rsp_in_degree,
   output logic [amge_pkg::DEG_W-1:0]      rsp_out_degree,
   output logic [amge_pkg::TDEG_W-1:0]     rsp_total_degree,
   output logic [amge_pkg::COUNT_W-1:0]    rsp_vertex_total,
   output logic [amge_pkg::EDGE_W-1:0]     rsp_edge_total,
   output logic                            rsp_graph_empty,
   output logic [amge_pkg::VERTEX_W-1:0]   rsp_neighbour_index,
   output logic                            rsp_neighbour_valid,
   output logic                            rsp_last,
   output logic [amge_pkg::ERR_W-1:0]      rsp_error_code
);

   amge_pkg::dp_cmd_type    cmd;
   amge_pkg::dp_status_type status;

   amge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   amge_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .req_kind            (req_kind),
      .req_first_vertex    (req_first_vertex),
      .req_second_vertex   (req_second_vertex),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_edge_present    (rsp_edge_present),
      .rsp_in_degree       (rsp_in_degree),
      .rsp_out_degree      (rsp_out_degree),
      .rsp_total_degree    (rsp_total_degree),
      .rsp_vertex_total    (rsp_vertex_total),
      .rsp_edge_total      (rsp_edge_total),
      .rsp_graph_empty     (rsp_graph_empty),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_neighbour_valid (rsp_neighbour_valid),
      .rsp_last            (rsp_last),
      .rsp_error_code      (rsp_error_code)
   );

endmodule

@@ hdl/amge_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the adjacency rows.
module amge_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = q_ff;

endmodule

@@ hdl/amge_dpath.sv @@
// Datapath of the graph engine: item registers, configuration registers,
// row RAM with per-row valid bits, counters and the result register.
// Depends on amge_pkg and amge_ram; driven by amge_ctrl commands.
module amge_dpath #(
   parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [amge_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [amge_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [amge_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   // item fields
   input  logic [amge_pkg::KIND_W-1:0]        req_kind,
   input  logic [amge_pkg::VERTEX_W-1:0]      req_first_vertex,
   input  logic [amge_pkg::VERTEX_W-1:0]      req_second_vertex,
   // controller link
   input  amge_pkg::dp_cmd_type               cmd,
   output amge_pkg::dp_status_type            status,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_edge_present,
   output logic [amge_pkg::DEG_W-1:0]         rsp_in_degree,
   output logic [amge_pkg::DEG_W-1:0]         rsp_out_degree,
   output logic [amge_pkg::TDEG_W-1:0]        rsp_total_degree,
   output logic [amge_pkg::COUNT_W-1:0]       rsp_vertex_total,
   output logic [amge_pkg::EDGE_W-1:0]        rsp_edge_total,
   output logic                               rsp_graph_empty,
   output logic [amge_pkg::VERTEX_W-1:0]      rsp_neighbour_index,
   output logic                               rsp_neighbour_valid,
   output logic                               rsp_last,
   output logic [amge_pkg::ERR_W-1:0]         rsp_error_code
);

   localparam int VW         = $clog2(MAX_VERTICES);
   localparam int CW         = $clog2(MAX_VERTICES + 1);
   localparam int TW         = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
   localparam int CMPW       = (CW > amge_pkg::START_W) ? CW : amge_pkg::START_W;
   localparam int LIVE_RESET = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

   // popcount of one row
   function automatic logic [CW-1:0] count_ones(input logic [MAX_VERTICES-1:0] row);
      logic [CW-1:0] sum;
      sum = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         sum = sum + CW'(row[i]);
      end
      return sum;
   endfunction

   // remove one column, higher columns move down one place
   function automatic logic [MAX_VERTICES-1:0] drop_col(
      input logic [MAX_VERTICES-1:0] row,
      input logic [VW-1:0]           col
   );
      logic [MAX_VERTICES-1:0] res;
      res = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (i < int'(col)) begin
            res[i] = row[i];
         end else if (i + 1 < MAX_VERTICES) begin
            res[i] = row[i + 1];
         end else begin
            res[i] = 1'b0;
         end
      end
      return res;
   endfunction

   // item registers
   logic [amge_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [amge_pkg::VERTEX_W-1:0] a_ff, a_in;
   logic [amge_pkg::VERTEX_W-1:0] b_ff, b_in;
   logic [amge_pkg::ERR_W-1:0]    err_ff, err_in;

   // configuration
   logic                          mode_ff, mode_in;
   logic [amge_pkg::START_W-1:0]  start_ff, start_in;

   // graph state
   logic [CW-1:0]                 live_ff, live_in;
   logic [TW-1:0]                 total_ff, total_in;
   logic [MAX_VERTICES-1:0]       valid_ff, valid_in;

   // sweep and accumulation
   logic [VW-1:0]                 cur_ff, cur_in;
   logic [TW-1:0]                 acc_ff, acc_in;
   logic [CW-1:0]                 indeg_ff, indeg_in;
   logic [CW-1:0]                 outdeg_ff, outdeg_in;
   logic                          edge_ff, edge_in;
   logic [MAX_VERTICES-1:0]       scan_ff, scan_in;
   logic [amge_pkg::RESULT_CNT_W-1:0] n_ff, n_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          rd_zero_ff, rd_zero_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_edge_present_ff, rsp_edge_present_in;
   logic [amge_pkg::DEG_W-1:0]    rsp_in_degree_ff, rsp_in_degree_in;
   logic [amge_pkg::DEG_W-1:0]    rsp_out_degree_ff, rsp_out_degree_in;
   logic [amge_pkg::TDEG_W-1:0]   rsp_total_degree_ff, rsp_total_degree_in;
   logic [amge_pkg::COUNT_W-1:0]  rsp_vertex_total_ff, rsp_vertex_total_in;
   logic [amge_pkg::EDGE_W-1:0]   rsp_edge_total_ff, rsp_edge_total_in;
   logic                          rsp_graph_empty_ff, rsp_graph_empty_in;
   logic [amge_pkg::VERTEX_W-1:0] rsp_neighbour_index_ff, rsp_neighbour_index_in;
   logic                          rsp_neighbour_valid_ff, rsp_neighbour_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [amge_pkg::ERR_W-1:0]    rsp_error_code_ff, rsp_error_code_in;

   // RAM port signals
   logic                          rd_en;
   logic [VW-1:0]                 rd_addr;
   logic [MAX_VERTICES-1:0]       ram_q;
   logic                          wr_en;
   logic [VW-1:0]                 wr_addr;
   logic [MAX_VERTICES-1:0]       wr_data;

   // helpers
   logic [VW-1:0]                 a_row, b_row;
   logic                          a_ok, b_ok, full;
   logic [amge_pkg::ERR_W-1:0]    err_now;
   logic [MAX_VERTICES-1:0]       rd_row;
   logic [MAX_VERTICES-1:0]       live_mask;
   logic [VW-1:0]                 edge_idx;
   logic [MAX_VERTICES-1:0]       edge_mask;
   logic                          edge_old;
   logic [MAX_VERTICES-1:0]       edge_row;
   logic [VW-1:0]                 rm_src;
   logic                          at_end;
   logic                          list_last;
   logic                          csr_write;

   amge_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign a_row  = VW'(a_ff);
   assign b_row  = VW'(b_ff);
   // rows never written since the last clear read as zero
   assign rd_row = (rd_valid_ff && !rd_zero_ff) ? ram_q : '0;
   assign at_end = (CW'(cur_ff) == (live_ff - CW'(1)));
   assign rm_src = (cur_ff >= a_row) ? VW'(CW'(cur_ff) + CW'(1)) : cur_ff;

   // range and capacity checks against the current vertex count
   always_comb begin
      a_ok = CMPW'(a_ff) < CMPW'(live_ff);
      b_ok = CMPW'(b_ff) < CMPW'(live_ff);
      full = live_ff >= CW'(MAX_VERTICES);
      unique case (kind_ff) inside
         amge_pkg::KIND_ADD_EDGE, amge_pkg::KIND_REMOVE_EDGE, amge_pkg::KIND_QUERY: begin
            err_now = (a_ok && b_ok) ? amge_pkg::ERR_NONE : amge_pkg::ERR_RANGE;
         end
         amge_pkg::KIND_REMOVE_VERTEX, amge_pkg::KIND_LIST: begin
            err_now = a_ok ? amge_pkg::ERR_NONE : amge_pkg::ERR_RANGE;
         end
         amge_pkg::KIND_ADD_VERTEX: begin
            err_now = full ? amge_pkg::ERR_FULL : amge_pkg::ERR_NONE;
         end
         default: begin
            err_now = amge_pkg::ERR_NONE;
         end
      endcase
   end

   // columns below the vertex count
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         live_mask[i] = CMPW'(i) < CMPW'(live_ff);
      end
   end

   // single-bit edge update on the row just read
   always_comb begin
      edge_idx  = (cmd.op == amge_pkg::DP_WR_EDGE_B) ? a_row : b_row;
      edge_mask = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << edge_idx;
      edge_old  = rd_row[edge_idx];
      edge_row  = (kind_ff == amge_pkg::KIND_ADD_EDGE) ? (rd_row | edge_mask)
                                                      : (rd_row & ~edge_mask);
   end

   assign list_last = (scan_ff[MAX_VERTICES-1:1] == '0) ||
                      (n_ff == amge_pkg::RESULT_CNT_W'(amge_pkg::MAX_RESULTS - 1));

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == amge_pkg::CSR_START_VERTICES)
                     ? amge_pkg::CSR_DATA_W'(start_ff)
                     : amge_pkg::CSR_DATA_W'(mode_ff);

   // next state of the datapath per micro-operation
   always_comb begin
      kind_in     = kind_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      err_in      = err_ff;
      mode_in     = mode_ff;
      start_in    = start_ff;
      live_in     = live_ff;
      total_in    = total_ff;
      valid_in    = valid_ff;
      cur_in      = cur_ff;
      acc_in      = acc_ff;
      indeg_in    = indeg_ff;
      outdeg_in   = outdeg_ff;
      edge_in     = edge_ff;
      scan_in     = scan_ff;
      n_in        = n_ff;
      rd_zero_in  = rd_zero_ff;
      rd_en       = 1'b0;
      rd_addr     = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_ff;
      wr_data     = edge_row;

      if (csr_write) begin
         if (csr_paddr[2] == amge_pkg::CSR_START_VERTICES) begin
            start_in = csr_pwdata[amge_pkg::START_W-1:0];
         end else begin
            mode_in = csr_pwdata[0];
         end
      end

      unique case (cmd.op)
         amge_pkg::DP_TAKE: begin
            kind_in = req_kind;
            a_in    = req_first_vertex;
            b_in    = req_second_vertex;
         end
         amge_pkg::DP_CHECK: begin
            err_in   = err_now;
            cur_in   = '0;
            acc_in   = '0;
            indeg_in = '0;
            n_in     = '0;
         end
         amge_pkg::DP_CLEAR: begin
            valid_in = '0;
            total_in = '0;
            live_in  = (CMPW'(start_ff) > CMPW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                               : CW'(start_ff);
         end
         amge_pkg::DP_ADD_VERTEX: begin
            // cells outside the live square are always zero: no sweep needed
            live_in = live_ff + CW'(1);
         end
         amge_pkg::DP_RD_FIRST: begin
            rd_en      = 1'b1;
            rd_addr    = a_row;
            rd_zero_in = 1'b0;
         end
         amge_pkg::DP_RD_SECOND: begin
            rd_en      = 1'b1;
            rd_addr    = b_row;
            rd_zero_in = 1'b0;
         end
         amge_pkg::DP_WR_EDGE_A, amge_pkg::DP_WR_EDGE_B: begin
            wr_en   = 1'b1;
            wr_addr = (cmd.op == amge_pkg::DP_WR_EDGE_B) ? b_row : a_row;
            wr_data = edge_row;
            valid_in[wr_addr] = 1'b1;
            if (kind_ff == amge_pkg::KIND_ADD_EDGE && !edge_old) begin
               total_in = total_ff + TW'(1);
            end else if (kind_ff == amge_pkg::KIND_REMOVE_EDGE && edge_old) begin
               total_in = total_ff - TW'(1);
            end
         end
         amge_pkg::DP_RM_READ: begin
            // rows at or above the removed vertex take the next row up;
            // the top live row becomes empty
            rd_en      = 1'b1;
            rd_addr    = rm_src;
            rd_zero_in = at_end;
         end
         amge_pkg::DP_RM_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = drop_col(rd_row, a_row);
            valid_in[cur_ff] = 1'b1;
            acc_in  = acc_ff + TW'(count_ones(drop_col(rd_row, a_row)));
            cur_in  = VW'(CW'(cur_ff) + CW'(1));
         end
         amge_pkg::DP_RM_FINISH: begin
            total_in = acc_ff;
            live_in  = live_ff - CW'(1);
         end
         amge_pkg::DP_Q_CAPTURE: begin
            outdeg_in = count_ones(rd_row);
            edge_in   = rd_row[b_row];
         end
         amge_pkg::DP_Q_READ: begin
            rd_en      = 1'b1;
            rd_addr    = cur_ff;
            rd_zero_in = 1'b0;
         end
         amge_pkg::DP_Q_ACC: begin
            indeg_in = indeg_ff + CW'(rd_row[a_row]);
            cur_in   = VW'(CW'(cur_ff) + CW'(1));
         end
         amge_pkg::DP_LIST_CAPTURE: begin
            scan_in = rd_row & live_mask;
         end
         amge_pkg::DP_LIST_SKIP: begin
            scan_in = scan_ff >> 1;
            cur_in  = VW'(CW'(cur_ff) + CW'(1));
         end
         amge_pkg::DP_LIST_EMIT: begin
            scan_in = scan_ff >> 1;
            cur_in  = VW'(CW'(cur_ff) + CW'(1));
            n_in    = n_ff + amge_pkg::RESULT_CNT_W'(1);
         end
         amge_pkg::DP_EMIT, amge_pkg::DP_NOP: begin
         end
         default: begin
         end
      endcase

      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   // result register: loads when the controller emits, frees when taken
   always_comb begin
      rsp_edge_present_in    = rsp_edge_present_ff;
      rsp_in_degree_in       = rsp_in_degree_ff;
      rsp_out_degree_in      = rsp_out_degree_ff;
      rsp_total_degree_in    = rsp_total_degree_ff;
      rsp_vertex_total_in    = rsp_vertex_total_ff;
      rsp_edge_total_in      = rsp_edge_total_ff;
      rsp_graph_empty_in     = rsp_graph_empty_ff;
      rsp_neighbour_index_in = rsp_neighbour_index_ff;
      rsp_neighbour_valid_in = rsp_neighbour_valid_ff;
      rsp_last_in            = rsp_last_ff;
      rsp_error_code_in      = rsp_error_code_ff;
      rsp_valid_in           = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.op == amge_pkg::DP_EMIT || cmd.op == amge_pkg::DP_LIST_EMIT) begin
         rsp_valid_in           = 1'b1;
         rsp_vertex_total_in    = amge_pkg::COUNT_W'(live_ff);
         rsp_edge_total_in      = mode_ff ? amge_pkg::EDGE_W'(total_ff)
                                          : amge_pkg::EDGE_W'(total_ff >> 1);
         rsp_graph_empty_in     = (total_ff == '0);
         rsp_edge_present_in    = 1'b0;
         rsp_in_degree_in       = '0;
         rsp_out_degree_in      = '0;
         rsp_total_degree_in    = '0;
         rsp_neighbour_index_in = '0;
         rsp_neighbour_valid_in = 1'b0;
         rsp_last_in            = 1'b1;
         rsp_error_code_in      = err_ff;
         if (cmd.op == amge_pkg::DP_LIST_EMIT) begin
            rsp_neighbour_index_in = amge_pkg::VERTEX_W'(cur_ff);
            rsp_neighbour_valid_in = 1'b1;
            rsp_last_in            = list_last;
         end else if (kind_ff == amge_pkg::KIND_QUERY && err_ff == amge_pkg::ERR_NONE) begin
            rsp_edge_present_in = edge_ff;
            rsp_in_degree_in    = amge_pkg::DEG_W'(indeg_ff);
            rsp_out_degree_in   = amge_pkg::DEG_W'(outdeg_ff);
            rsp_total_degree_in = mode_ff
                                ? amge_pkg::TDEG_W'({1'b0, indeg_ff} + {1'b0, outdeg_ff})
                                : amge_pkg::TDEG_W'(outdeg_ff);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         start_ff     <= amge_pkg::START_RESET;
         live_ff      <= CW'(LIVE_RESET);
         total_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         live_ff      <= live_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      kind_ff                <= kind_in;
      a_ff                   <= a_in;
      b_ff                   <= b_in;
      err_ff                 <= err_in;
      cur_ff                 <= cur_in;
      acc_ff                 <= acc_in;
      indeg_ff               <= indeg_in;
      outdeg_ff              <= outdeg_in;
      edge_ff                <= edge_in;
      scan_ff                <= scan_in;
      n_ff                   <= n_in;
      rd_valid_ff            <= rd_valid_in;
      rd_zero_ff             <= rd_zero_in;
      rsp_edge_present_ff    <= rsp_edge_present_in;
      rsp_in_degree_ff       <= rsp_in_degree_in;
      rsp_out_degree_ff      <= rsp_out_degree_in;
      rsp_total_degree_ff    <= rsp_total_degree_in;
      rsp_vertex_total_ff    <= rsp_vertex_total_in;
      rsp_edge_total_ff      <= rsp_edge_total_in;
      rsp_graph_empty_ff     <= rsp_graph_empty_in;
      rsp_neighbour_index_ff <= rsp_neighbour_index_in;
      rsp_neighbour_valid_ff <= rsp_neighbour_valid_in;
      rsp_last_ff            <= rsp_last_in;
      rsp_error_code_ff      <= rsp_error_code_in;
   end

   // status to the controller
   always_comb begin
      status.kind       = kind_ff;
      status.err_none   = (err_now == amge_pkg::ERR_NONE);
      status.directed   = mode_ff;
      status.sweep_last = at_end;
      status.scan_hit   = scan_ff[0];
      status.list_last  = list_last;
      status.row_empty  = (scan_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_edge_present    = rsp_edge_present_ff;
   assign rsp_in_degree       = rsp_in_degree_ff;
   assign rsp_out_degree      = rsp_out_degree_ff;
   assign rsp_total_degree    = rsp_total_degree_ff;
   assign rsp_vertex_total    = rsp_vertex_total_ff;
   assign rsp_edge_total      = rsp_edge_total_ff;
   assign rsp_graph_empty     = rsp_graph_empty_ff;
   assign rsp_neighbour_index = rsp_neighbour_index_ff;
   assign rsp_neighbour_valid = rsp_neighbour_valid_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_error_code      = rsp_error_code_ff;

endmodule

@@ hdl/amge_ctrl.sv @@
// Controller of the graph engine: sequences each item into datapath
// micro-operations and owns the input handshake. Depends on amge_pkg.
module amge_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  amge_pkg::dp_status_type status,
   output amge_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_ADD_VERTEX,
      ST_EDGE_RD_A,
      ST_EDGE_WR_A,
      ST_EDGE_RD_B,
      ST_EDGE_WR_B,
      ST_RM_RD,
      ST_RM_WR,
      ST_RM_FINISH,
      ST_Q_RD_A,
      ST_Q_CAPTURE,
      ST_Q_RD,
      ST_Q_ACC,
      ST_L_RD_A,
      ST_L_CAPTURE,
      ST_L_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // next state and command
   always_comb begin
      state_in  = state_ff;
      cmd.op    = amge_pkg::DP_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = amge_pkg::DP_TAKE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.op = amge_pkg::DP_CHECK;
            if (!status.err_none) begin
               state_in = ST_EMIT;
            end else begin
               unique case (status.kind) inside
                  amge_pkg::KIND_CLEAR:         state_in = ST_CLEAR;
                  amge_pkg::KIND_ADD_EDGE,
                  amge_pkg::KIND_REMOVE_EDGE:   state_in = ST_EDGE_RD_A;
                  amge_pkg::KIND_ADD_VERTEX:    state_in = ST_ADD_VERTEX;
                  amge_pkg::KIND_REMOVE_VERTEX: state_in = ST_RM_RD;
                  amge_pkg::KIND_QUERY:         state_in = ST_Q_RD_A;
                  amge_pkg::KIND_LIST:          state_in = ST_L_RD_A;
                  default:                      state_in = ST_EMIT;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.op   = amge_pkg::DP_CLEAR;
            state_in = ST_EMIT;
         end
         ST_ADD_VERTEX: begin
            cmd.op   = amge_pkg::DP_ADD_VERTEX;
            state_in = ST_EMIT;
         end
         // edge change, mirrored when undirected
         ST_EDGE_RD_A: begin
            cmd.op   = amge_pkg::DP_RD_FIRST;
            state_in = ST_EDGE_WR_A;
         end
         ST_EDGE_WR_A: begin
            cmd.op   = amge_pkg::DP_WR_EDGE_A;
            state_in = status.directed ? ST_EMIT : ST_EDGE_RD_B;
         end
         ST_EDGE_RD_B: begin
            cmd.op   = amge_pkg::DP_RD_SECOND;
            state_in = ST_EDGE_WR_B;
         end
         ST_EDGE_WR_B: begin
            cmd.op   = amge_pkg::DP_WR_EDGE_B;
            state_in = ST_EMIT;
         end
         // vertex removal: read, shift and rewrite each live row
         ST_RM_RD: begin
            cmd.op   = amge_pkg::DP_RM_READ;
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            cmd.op   = amge_pkg::DP_RM_WRITE;
            state_in = status.sweep_last ? ST_RM_FINISH : ST_RM_RD;
         end
         ST_RM_FINISH: begin
            cmd.op   = amge_pkg::DP_RM_FINISH;
            state_in = ST_EMIT;
         end
         // query: own row, then column sweep for the in-degree
         ST_Q_RD_A: begin
            cmd.op   = amge_pkg::DP_RD_FIRST;
            state_in = ST_Q_CAPTURE;
         end
         ST_Q_CAPTURE: begin
            cmd.op   = amge_pkg::DP_Q_CAPTURE;
            state_in = ST_Q_RD;
         end
         ST_Q_RD: begin
            cmd.op   = amge_pkg::DP_Q_READ;
            state_in = ST_Q_ACC;
         end
         ST_Q_ACC: begin
            cmd.op   = amge_pkg::DP_Q_ACC;
            state_in = status.sweep_last ? ST_EMIT : ST_Q_RD;
         end
         // neighbour listing: one column per cycle unless a hit waits for the result register, one item per hit
         ST_L_RD_A: begin
            cmd.op   = amge_pkg::DP_RD_FIRST;
            state_in = ST_L_CAPTURE;
         end
         ST_L_CAPTURE: begin
            cmd.op   = amge_pkg::DP_LIST_CAPTURE;
            state_in = ST_L_SCAN;
         end
         ST_L_SCAN: begin
            if (status.row_empty) begin
               state_in = ST_EMIT;
            end else if (status.scan_hit) begin
               if (status.out_free) begin
                  cmd.op = amge_pkg::DP_LIST_EMIT;
                  if (status.list_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.op = amge_pkg::DP_LIST_SKIP;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = amge_pkg::DP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
